FILE: rtl/core/ssm_pkg.sv
// shared types and constants for the sample set median block
// command and status groups between the controller and the datapath
// no dependencies
package ssm_pkg;

   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned CNT_W    = 7;

   // read address selection of the datapath
   localparam logic [1:0] RD_PREV   = 2'd0;
   localparam logic [1:0] RD_PREV2  = 2'd1;
   localparam logic [1:0] RD_MED_LO = 2'd2;
   localparam logic [1:0] RD_MED_HI = 2'd3;

   typedef struct packed {
      logic       load;         // capture the incoming sample
      logic       drop;         // store full, mark the set as overflowed
      logic       shift;        // move the entry read back one place up
      logic       place;        // write the sample at the insert position
      logic       lo_load;      // capture the lower middle element
      logic       result_load;  // form the result and empty the store
      logic [1:0] rd_sel;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic pos_zero;
      logic pos_one;
      logic greater;
      logic last;
   } status_type;

endpackage

FILE: rtl/core/ssm_ram.sv
// generic single write, single read memory with registered read data
// no dependencies
module ssm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/ssm_datapath.sv
// datapath of the sample set median block: sorted store, insert position,
// count, overflow flag and result registers; uses ssm_pkg and ssm_ram
module ssm_datapath #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ssm_pkg::cmd_type                    cmd,
   output ssm_pkg::status_type                 status,
   input  logic [ssm_pkg::SAMPLE_W-1:0]        in_sample,
   input  logic                                in_last,
   output logic [ssm_pkg::SAMPLE_W-1:0]        out_median,
   output logic [ssm_pkg::CNT_W-1:0]           out_count,
   output logic                                out_overflow
);
   import ssm_pkg::*;

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                last_ff, last_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic                drop_ff, drop_in;
   logic [SAMPLE_W-1:0] lo_ff, lo_in;
   logic [SAMPLE_W-1:0] median_ff, median_in;
   logic [CNT_W-1:0]    cnt_out_ff, cnt_out_in;
   logic                ovf_ff, ovf_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [SAMPLE_W-1:0] wr_data;
   logic [AW-1:0]       rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   logic [CW-1:0]       half;
   logic [CW-1:0]       rd_full;
   logic [SAMPLE_W:0]   mid_sum;
   logic [CW+CNT_W-1:0] count_ext;

   ssm_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign half = count_ff >> 1;

   always_comb begin
      case (cmd.rd_sel)
         RD_PREV:   rd_full = pos_ff - CW'(1);
         RD_PREV2:  rd_full = pos_ff - CW'(2);
         RD_MED_LO: rd_full = half - {{(CW-1){1'b0}}, ~count_ff[0]};
         RD_MED_HI: rd_full = half;
         default:   rd_full = half;
      endcase
   end

   assign rd_addr = rd_full[AW-1:0];
   assign wr_en   = cmd.shift | cmd.place;
   assign wr_addr = pos_ff[AW-1:0];
   assign wr_data = cmd.shift ? rd_data : sample_ff;

   // floor of the mean of the two middle elements, summed at 33 bits
   assign mid_sum   = {lo_ff[SAMPLE_W-1], lo_ff} + {rd_data[SAMPLE_W-1], rd_data};
   assign count_ext = {{CNT_W{1'b0}}, count_ff};

   always_comb begin
      sample_in  = sample_ff;
      last_in    = last_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      drop_in    = drop_ff;
      lo_in      = lo_ff;
      median_in  = median_ff;
      cnt_out_in = cnt_out_ff;
      ovf_in     = ovf_ff;
      if (cmd.load) begin
         sample_in = in_sample;
         last_in   = in_last;
         pos_in    = count_ff;
      end
      if (cmd.drop) begin
         drop_in = 1'b1;
      end
      if (cmd.shift) begin
         pos_in = pos_ff - CW'(1);
      end
      if (cmd.place) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.lo_load) begin
         lo_in = rd_data;
      end
      if (cmd.result_load) begin
         median_in  = count_ff[0] ? lo_ff : mid_sum[SAMPLE_W:1];
         cnt_out_in = count_ext[CNT_W-1:0];
         ovf_in     = drop_ff;
         count_in   = '0;
         drop_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      last_ff    <= last_in;
      pos_ff     <= pos_in;
      lo_ff      <= lo_in;
      median_ff  <= median_in;
      cnt_out_ff <= cnt_out_in;
      ovf_ff     <= ovf_in;
   end

   assign status.full     = (count_ff == CW'(CAPACITY));
   assign status.pos_zero = (pos_ff == '0);
   assign status.pos_one  = (pos_ff == CW'(1));
   assign status.greater  = ($signed(rd_data) > $signed(sample_ff));
   assign status.last     = last_ff;

   assign out_median   = median_ff;
   assign out_count    = cnt_out_ff;
   assign out_overflow = ovf_ff;

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> (pos_ff != '0))
      else $error("shift below the bottom of the store");

   a_place_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> (count_ff < CW'(CAPACITY)))
      else $error("sample placed into a full store");

   a_result_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (count_ff != '0))
      else $error("result formed over an empty store");

   a_emptied: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |=> (count_ff == '0) && !drop_ff)
      else $error("store not emptied after result");

endmodule

FILE: rtl/core/ssm_ctrl.sv
// controller of the sample set median block: insertion scan, median reads
// and the handshakes of both channels; uses ssm_pkg
module ssm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output ssm_pkg::cmd_type    cmd,
   input  ssm_pkg::status_type status
);
   import ssm_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN_REQ = 3'd1;
   localparam logic [2:0] ST_SCAN_CMP = 3'd2;
   localparam logic [2:0] ST_MED_RD1  = 3'd3;
   localparam logic [2:0] ST_MED_RD2  = 3'd4;
   localparam logic [2:0] ST_MED_CAP  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = '0;
      cmd.rd_sel   = RD_PREV;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (status.full) begin
                  cmd.drop = 1'b1;
                  state_in = req_tlast ? ST_MED_RD1 : ST_IDLE;
               end else begin
                  state_in = ST_SCAN_REQ;
               end
            end
         end
         ST_SCAN_REQ: begin
            if (status.pos_zero) begin
               cmd.place = 1'b1;
               state_in  = status.last ? ST_MED_RD1 : ST_IDLE;
            end else begin
               cmd.rd_sel = RD_PREV;
               state_in   = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (status.greater) begin
               cmd.shift = 1'b1;
               if (status.pos_one) begin
                  state_in = ST_SCAN_REQ;
               end else begin
                  // next lower entry is read while this one moves up
                  cmd.rd_sel = RD_PREV2;
               end
            end else begin
               cmd.place = 1'b1;
               state_in  = status.last ? ST_MED_RD1 : ST_IDLE;
            end
         end
         ST_MED_RD1: begin
            cmd.rd_sel = RD_MED_LO;
            state_in   = ST_MED_RD2;
         end
         ST_MED_RD2: begin
            cmd.rd_sel  = RD_MED_HI;
            cmd.lo_load = 1'b1;
            state_in    = ST_MED_CAP;
         end
         ST_MED_CAP: begin
            cmd.rd_sel = RD_MED_HI;
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrites a transaction not yet taken");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |=> rsp_tvalid)
      else $error("result formed but not presented");

   a_no_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |-> !cmd.shift && !cmd.place && !cmd.result_load)
      else $error("store written in the accepting cycle");

endmodule

FILE: rtl/core/sample_set_median.sv
// top level of the sample set median block
// joins ssm_ctrl and ssm_datapath; uses ssm_pkg
//
// Samples of a set are kept in ascending order in a single-port-write,
// single-port-read store of CAPACITY entries. Each sample is inserted by
// a scan that walks down from the top of the store, moving every larger
// entry up one place per cycle; a sample that arrives with the store
// full is dropped. The transaction marked with tlast adds the two middle
// reads and the averaging, and is held while the previous result still
// waits to be taken, after which one result is presented and the store
// is emptied. The result waits in an output register while the next set
// is already being taken in.
module sample_set_median #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample
   input  logic        req_tlast,   // last_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // median_value, sample_count, overflow
);
   import ssm_pkg::*;

   cmd_type             cmd;
   status_type          status;
   logic [SAMPLE_W-1:0] median;
   logic [CNT_W-1:0]    count;
   logic                overflow;

   ssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd),
      .status    (status)
   );

   ssm_datapath #(
      .CAPACITY(CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_sample   (req_tdata),
      .in_last     (req_tlast),
      .out_median  (median),
      .out_count   (count),
      .out_overflow(overflow)
   );

   assign rsp_tdata = {overflow, count, median};

endmodule
